// ----- hw/rtl/dsf_pkg.sv -----
package dsf_pkg;

	// Configuration register indexes (byte address is 4 times the index).
	localparam logic [2:0] REG_DEPTH_ORIGIN = 3'd0;
	localparam logic [2:0] REG_DEPTH_STEP_X = 3'd1;
	localparam logic [2:0] REG_DEPTH_STEP_Y = 3'd2;
	localparam logic [2:0] REG_BUFFER_WIDTH = 3'd3;
	localparam logic [2:0] REG_BUFFER_BASE  = 3'd4;

	localparam int PADDR_W = 5;
	localparam int VALUE_W = 32;
	localparam int ADDR_W  = 24;
	localparam int DEPTH_W = 16;
	localparam int BWIDTH_W = 11;
	localparam int COORD_W = 10;
	localparam int LEN_IN_W = 7;

	localparam logic [BWIDTH_W-1:0] BUFFER_WIDTH_RESET = 11'd320;

	// Handshake between a producer and the span queue.
	typedef struct packed {
		logic push;
		logic full;
	} dsf_push_t;

	// Handshake between the span queue and the pixel emitter.
	typedef struct packed {
		logic pop;
		logic empty;
	} dsf_pop_t;

endpackage

// ----- hw/rtl/dsf_front.sv -----
module dsf_front #(
	parameter int MAX_SPAN = 64,
	parameter int MAX_SCREEN_WIDTH = 1024,
	parameter int SPAN_W = $clog2(MAX_SPAN + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic [dsf_pkg::COORD_W-1:0]    span_x,
	input  logic [dsf_pkg::COORD_W-1:0]    span_y,
	input  logic [dsf_pkg::LEN_IN_W-1:0]   span_length,
	input  logic [dsf_pkg::VALUE_W-1:0]    depth_origin,
	input  logic [dsf_pkg::VALUE_W-1:0]    depth_step_x,
	input  logic [dsf_pkg::VALUE_W-1:0]    depth_step_y,
	input  logic [dsf_pkg::BWIDTH_W-1:0]   buffer_width,
	input  logic [dsf_pkg::ADDR_W-1:0]     buffer_base,
	output logic                           occupied,
	output logic                           push,
	output logic [dsf_pkg::VALUE_W-1:0]    acc,
	output logic [dsf_pkg::ADDR_W-1:0]     addr,
	output logic [SPAN_W-1:0]              len
);

	localparam int WSAT_W = $clog2(MAX_SCREEN_WIDTH + 1);

	logic [31:0]                        len_ext;
	logic [31:0]                        width_ext;
	logic [SPAN_W-1:0]                  len_sat;
	logic [WSAT_W-1:0]                  width_sat;

	logic                               valid_s1;
	logic [dsf_pkg::VALUE_W-1:0]        prod_x_s1;
	logic [dsf_pkg::VALUE_W-1:0]        prod_y_s1;
	logic [dsf_pkg::ADDR_W-1:0]         prod_w_s1;
	logic [dsf_pkg::COORD_W-1:0]        x_s1;
	logic [SPAN_W-1:0]                  len_s1;

	logic                               valid_s2;
	logic [dsf_pkg::VALUE_W-1:0]        acc_s2;
	logic [dsf_pkg::ADDR_W-1:0]         addr_s2;
	logic [SPAN_W-1:0]                  len_s2;

	// Clamp the piece length and the row length to what the hardware covers.
	always_comb begin
		len_ext   = 32'(span_length);
		width_ext = 32'(buffer_width);
		if (len_ext > 32'(MAX_SPAN)) begin
			len_sat = SPAN_W'(MAX_SPAN);
		end else begin
			len_sat = SPAN_W'(len_ext);
		end
		if (width_ext > 32'(MAX_SCREEN_WIDTH)) begin
			width_sat = WSAT_W'(MAX_SCREEN_WIDTH);
		end else begin
			width_sat = WSAT_W'(width_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			// A zero-length piece produces nothing and is dropped here.
			valid_s2 <= valid_s1 && (len_s1 != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prod_x_s1 <= dsf_pkg::VALUE_W'(span_x) * depth_step_x;
			prod_y_s1 <= dsf_pkg::VALUE_W'(span_y) * depth_step_y;
			prod_w_s1 <= dsf_pkg::ADDR_W'(width_sat) * dsf_pkg::ADDR_W'(span_y);
			x_s1      <= span_x;
			len_s1    <= len_sat;
		end
		if (valid_s1) begin
			acc_s2  <= depth_origin + prod_y_s1 + prod_x_s1;
			addr_s2 <= buffer_base + prod_w_s1 + dsf_pkg::ADDR_W'(x_s1);
			len_s2  <= len_s1;
		end
	end

	assign occupied = valid_s1 || valid_s2;
	assign push     = valid_s2;
	assign acc      = acc_s2;
	assign addr     = addr_s2;
	assign len      = len_s2;

endmodule

// ----- hw/rtl/dsf_queue.sv -----
module dsf_queue #(
	parameter int WIDTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dsf_pkg::dsf_push_t   wr_ctl_in,
	output logic                 full,
	input  logic [WIDTH-1:0]     wr_data,
	input  logic                 pop,
	output logic                 empty,
	output logic [WIDTH-1:0]     rd_data
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);

	logic [WIDTH-1:0]   entry_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     count_q;
	logic               do_push;
	logic               do_pop;

	assign full    = (count_q == (PTR_W+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = wr_ctl_in.push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ----- hw/rtl/dsf_back.sv -----
module dsf_back #(
	parameter int SPAN_W = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          empty,
	input  logic [dsf_pkg::VALUE_W-1:0]   q_acc,
	input  logic [dsf_pkg::ADDR_W-1:0]    q_addr,
	input  logic [SPAN_W-1:0]             q_len,
	output dsf_pkg::dsf_pop_t             pop_ctl,
	input  logic [dsf_pkg::VALUE_W-1:0]   depth_step_x,
	output logic                          strobe,
	output logic [dsf_pkg::ADDR_W-1:0]    depth_address,
	output logic [dsf_pkg::DEPTH_W-1:0]   depth_value,
	output logic                          last_pixel
);

	logic                          active_q;
	logic                          strobe_q;
	logic [dsf_pkg::VALUE_W-1:0]   acc_q;
	logic [dsf_pkg::ADDR_W-1:0]    addr_q;
	logic [SPAN_W-1:0]             rem_q;
	logic [dsf_pkg::ADDR_W-1:0]    out_addr_q;
	logic [dsf_pkg::DEPTH_W-1:0]   out_value_q;
	logic                          out_last_q;
	logic                          final_pixel;
	logic                          load;

	// The next piece, if one is queued, is taken in the cycle in which the current one steps its last pixel.
	assign final_pixel   = active_q && (rem_q == SPAN_W'(1));
	assign load          = !empty && (!active_q || final_pixel);
	assign pop_ctl.pop   = load;
	assign pop_ctl.empty = empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
			if (load) begin
				active_q <= 1'b1;
			end else if (final_pixel) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (active_q) begin
			out_addr_q  <= addr_q;
			out_value_q <= acc_q[dsf_pkg::VALUE_W-1 -: dsf_pkg::DEPTH_W];
			out_last_q  <= final_pixel;
		end
		if (load) begin
			acc_q  <= q_acc;
			addr_q <= q_addr;
			rem_q  <= q_len;
		end else if (active_q) begin
			acc_q  <= acc_q + depth_step_x;
			addr_q <= addr_q + 1'b1;
			rem_q  <= rem_q - 1'b1;
		end
	end

	assign strobe        = strobe_q;
	assign depth_address = out_addr_q;
	assign depth_value   = out_value_q;
	assign last_pixel    = out_last_q;

endmodule

// ----- hw/rtl/depth_span_fill_top.sv -----
// The first depth write of a span shows on the result ports once its request has passed
// the front end, the queue and the emitter; the remaining pixels follow one per cycle with no gaps.
// Depth writes come out one per cycle while pieces are queued; a piece is up to 64 pixels.
// The front end takes a new request once its stages are empty and while the queue has room.
// Reset (arst_n low) empties the pipeline and queue and loads the register reset values.
// Results are strobed for a single cycle; the receiver cannot stall them.
module depth_span_fill_top #(
	parameter int MAX_SPAN = 64,
	parameter int MAX_SCREEN_WIDTH = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Span requests.
	input  logic                           start,
	output logic                           busy,
	input  logic [dsf_pkg::COORD_W-1:0]    span_x,
	input  logic [dsf_pkg::COORD_W-1:0]    span_y,
	input  logic [dsf_pkg::LEN_IN_W-1:0]   span_length,
	// Depth writes.
	output logic                           strobe,
	output logic [dsf_pkg::ADDR_W-1:0]     depth_address,
	output logic [dsf_pkg::DEPTH_W-1:0]    depth_value,
	output logic                           last_pixel,
	// Register port.
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [dsf_pkg::PADDR_W-1:0]    paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);

	localparam int SPAN_W = $clog2(MAX_SPAN + 1);
	localparam int ENTRY_W = dsf_pkg::VALUE_W + dsf_pkg::ADDR_W + SPAN_W;

	// Register file. Signed plane values are held as raw two's complement bits.
	logic [dsf_pkg::VALUE_W-1:0]    depth_origin_q;
	logic [dsf_pkg::VALUE_W-1:0]    depth_step_x_q;
	logic [dsf_pkg::VALUE_W-1:0]    depth_step_y_q;
	logic [dsf_pkg::BWIDTH_W-1:0]   buffer_width_q;
	logic [dsf_pkg::ADDR_W-1:0]     buffer_base_q;
	logic                           reg_write;
	logic [2:0]                     reg_index;

	logic                           accept;
	logic                           front_occupied;
	dsf_pkg::dsf_push_t             push_ctl;
	dsf_pkg::dsf_pop_t              pop_ctl;
	logic [dsf_pkg::VALUE_W-1:0]    front_acc;
	logic [dsf_pkg::ADDR_W-1:0]     front_addr;
	logic [SPAN_W-1:0]              front_len;
	logic [ENTRY_W-1:0]             q_rd_data;
	logic                           q_full;
	logic                           q_empty;

	assign pready    = 1'b1;
	assign reg_write = psel && penable && pwrite && pready;
	assign reg_index = paddr[dsf_pkg::PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_origin_q <= '0;
			depth_step_x_q <= '0;
			depth_step_y_q <= '0;
			buffer_width_q <= dsf_pkg::BUFFER_WIDTH_RESET;
			buffer_base_q  <= '0;
		end else if (reg_write) begin
			case (reg_index)
				dsf_pkg::REG_DEPTH_ORIGIN: depth_origin_q <= pwdata;
				dsf_pkg::REG_DEPTH_STEP_X: depth_step_x_q <= pwdata;
				dsf_pkg::REG_DEPTH_STEP_Y: depth_step_y_q <= pwdata;
				dsf_pkg::REG_BUFFER_WIDTH: buffer_width_q <= pwdata[dsf_pkg::BWIDTH_W-1:0];
				dsf_pkg::REG_BUFFER_BASE:  buffer_base_q  <= pwdata[dsf_pkg::ADDR_W-1:0];
				default: ; // Addresses past the register list are ignored.
			endcase
		end
	end

	always_comb begin
		case (reg_index)
			dsf_pkg::REG_DEPTH_ORIGIN: prdata = depth_origin_q;
			dsf_pkg::REG_DEPTH_STEP_X: prdata = depth_step_x_q;
			dsf_pkg::REG_DEPTH_STEP_Y: prdata = depth_step_y_q;
			dsf_pkg::REG_BUFFER_WIDTH: prdata = 32'(buffer_width_q);
			dsf_pkg::REG_BUFFER_BASE:  prdata = 32'(buffer_base_q);
			default:                   prdata = '0;
		endcase
	end

	// The front end holds one request at a time in its two stages. The queue
	// can never overflow: a request is only taken when the stages are empty and
	// the queue has a free slot, and the emitter only ever drains the queue.
	assign busy   = front_occupied || q_full;
	assign accept = start && !busy;

	dsf_front #(
		.MAX_SPAN         (MAX_SPAN),
		.MAX_SCREEN_WIDTH (MAX_SCREEN_WIDTH),
		.SPAN_W           (SPAN_W)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.span_x       (span_x),
		.span_y       (span_y),
		.span_length  (span_length),
		.depth_origin (depth_origin_q),
		.depth_step_x (depth_step_x_q),
		.depth_step_y (depth_step_y_q),
		.buffer_width (buffer_width_q),
		.buffer_base  (buffer_base_q),
		.occupied     (front_occupied),
		.push         (push_ctl.push),
		.acc          (front_acc),
		.addr         (front_addr),
		.len          (front_len)
	);

	assign push_ctl.full = q_full;

	// Short queue of prepared pieces: start value, start address, pixel count.
	dsf_queue #(
		.WIDTH (ENTRY_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_ctl_in (push_ctl),
		.full      (q_full),
		.wr_data   ({front_acc, front_addr, front_len}),
		.pop       (pop_ctl.pop),
		.empty     (q_empty),
		.rd_data   (q_rd_data)
	);

	// The emitter steps the running 1/z value and the address once per pixel.
	dsf_back #(
		.SPAN_W (SPAN_W)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.empty         (q_empty),
		.q_acc         (q_rd_data[ENTRY_W-1 -: dsf_pkg::VALUE_W]),
		.q_addr        (q_rd_data[SPAN_W +: dsf_pkg::ADDR_W]),
		.q_len         (q_rd_data[SPAN_W-1:0]),
		.pop_ctl       (pop_ctl),
		.depth_step_x  (depth_step_x_q),
		.strobe        (strobe),
		.depth_address (depth_address),
		.depth_value   (depth_value),
		.last_pixel    (last_pixel)
	);

endmodule

// ----- hw/rtl/dsf_checker.sv -----
module dsf_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic                           strobe,
	input logic [dsf_pkg::ADDR_W-1:0]     depth_address,
	input logic                           last_pixel,
	input logic                           pready
);

	// An accepted request occupies the front end on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted but block not busy afterward");

	// Pixels of one span come out on consecutive cycles.
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_pixel |=> strobe)
		else $error("gap inside a span");

	// Addresses within a span step by one element.
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_pixel |=> depth_address == $past(depth_address) + 1'b1)
		else $error("span address did not advance by one");

	// No depth write appears, and the register port is ready, on the cycle right after reset is released.
	assert property (@(posedge clk)
		$rose(arst_n) |-> !strobe && pready)
		else $error("result strobe out of reset");

endmodule

bind depth_span_fill_top dsf_checker u_dsf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.strobe        (strobe),
	.depth_address (depth_address),
	.last_pixel    (last_pixel),
	.pready        (pready)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

// Span fill check: span requests go in through the command port, every depth write that
// comes out is compared against a local prediction of the 1/z plane and the buffer address.
module testbench;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PIXELS_PER_SPAN = 64;
	localparam int ROW_LIMIT = 1024;
	localparam int REPORT_LIMIT = 10;
	// Cycles to let the pipeline drain before the registers are touched.
	localparam int DRAIN_CYCLES = 16;
	// Index past the end of the register list; writes to it must change nothing.
	localparam logic [2:0] REG_UNUSED = 3'd5;

	typedef struct packed {
		logic [dsf_pkg::COORD_W-1:0]  x;
		logic [dsf_pkg::COORD_W-1:0]  y;
		logic [dsf_pkg::LEN_IN_W-1:0] len;
	} span_req_t;

	typedef struct packed {
		logic [dsf_pkg::ADDR_W-1:0]  addr;
		logic [dsf_pkg::DEPTH_W-1:0] value;
		logic                        last;
	} depth_write_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [dsf_pkg::COORD_W-1:0] span_x = '0;
	logic [dsf_pkg::COORD_W-1:0] span_y = '0;
	logic [dsf_pkg::LEN_IN_W-1:0] span_length = '0;
	logic strobe;
	logic [dsf_pkg::ADDR_W-1:0] depth_address;
	logic [dsf_pkg::DEPTH_W-1:0] depth_value;
	logic last_pixel;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [dsf_pkg::PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// Local copy of the plane and buffer registers.
	logic [dsf_pkg::VALUE_W-1:0] plane_origin = '0;
	logic [dsf_pkg::VALUE_W-1:0] plane_step_x = '0;
	logic [dsf_pkg::VALUE_W-1:0] plane_step_y = '0;
	logic [dsf_pkg::BWIDTH_W-1:0] row_pitch = dsf_pkg::BUFFER_WIDTH_RESET;
	logic [dsf_pkg::ADDR_W-1:0] depth_base = '0;

	span_req_t pending_spans[$];
	depth_write_t depth_writes_due[$];
	span_req_t queued_span;
	int sender_idle_pct = 0;
	int failures = 0;
	int cycle_count = 0;

	depth_span_fill_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.span_x(span_x),
		.span_y(span_y),
		.span_length(span_length),
		.strobe(strobe),
		.depth_address(depth_address),
		.depth_value(depth_value),
		.last_pixel(last_pixel),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	// Works out the depth writes one accepted request must produce, in emission order.
	function automatic void predict_span_writes(span_req_t req);
		logic [dsf_pkg::VALUE_W-1:0] running;
		logic [dsf_pkg::ADDR_W-1:0] addr;
		logic [dsf_pkg::BWIDTH_W-1:0] pitch;
		depth_write_t wr;
		int pixels;
		pixels = (req.len > PIXELS_PER_SPAN) ? PIXELS_PER_SPAN : int'(req.len);
		pitch = (row_pitch > ROW_LIMIT) ? dsf_pkg::BWIDTH_W'(ROW_LIMIT) : row_pitch;
		running = plane_origin + {22'b0, req.y} * plane_step_y + {22'b0, req.x} * plane_step_x;
		addr = depth_base + {13'b0, pitch} * {14'b0, req.y} + {14'b0, req.x};
		for (int i = 0; i < pixels; i++) begin
			wr.addr = addr;
			wr.value = running[31:16];
			wr.last = (i == pixels - 1);
			depth_writes_due.push_back(wr);
			running = running + plane_step_x;
			addr = addr + 1'b1;
		end
	endfunction

	// Request driver. A request stands on the port until the edge that accepts it; between
	// requests the fields carry noise that the block must ignore.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			span_x <= '0;
			span_y <= '0;
			span_length <= '0;
		end else if (!start || !busy) begin
			if (start)
				predict_span_writes(span_req_t'{span_x, span_y, span_length});
			if (pending_spans.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				queued_span = pending_spans.pop_front();
				start <= 1'b1;
				span_x <= queued_span.x;
				span_y <= queued_span.y;
				span_length <= queued_span.len;
			end else begin
				start <= 1'b0;
				span_x <= dsf_pkg::COORD_W'($urandom);
				span_y <= dsf_pkg::COORD_W'($urandom);
				span_length <= dsf_pkg::LEN_IN_W'($urandom);
			end
		end
	end

	// Depth write monitor: every strobe is matched against the oldest outstanding write.
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (depth_writes_due.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("unexpected depth write: addr %h value %h last %b",
						depth_address, depth_value, last_pixel);
			end else begin
				automatic depth_write_t want = depth_writes_due.pop_front();
				if (want.addr !== depth_address || want.value !== depth_value ||
						want.last !== last_pixel) begin
					failures++;
					if (failures <= REPORT_LIMIT)
						$display({"depth write mismatch: expected addr %h value %h last %b,",
							" got addr %h value %h last %b"},
							want.addr, want.value, want.last,
							depth_address, depth_value, last_pixel);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("depth_span_fill_top test failed");
			$finish;
		end
	end

	// Two-phase register write; the local copy follows at the edge that commits it.
	task automatic reg_write(logic [2:0] idx, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			dsf_pkg::REG_DEPTH_ORIGIN: plane_origin = data;
			dsf_pkg::REG_DEPTH_STEP_X: plane_step_x = data;
			dsf_pkg::REG_DEPTH_STEP_Y: plane_step_y = data;
			dsf_pkg::REG_BUFFER_WIDTH: row_pitch = data[dsf_pkg::BWIDTH_W-1:0];
			dsf_pkg::REG_BUFFER_BASE:  depth_base = data[dsf_pkg::ADDR_W-1:0];
			default: ;
		endcase
	endtask

	task automatic program_plane(logic [31:0] origin, logic [31:0] step_x,
			logic [31:0] step_y, logic [31:0] pitch, logic [31:0] base);
		reg_write(dsf_pkg::REG_DEPTH_ORIGIN, origin);
		reg_write(dsf_pkg::REG_DEPTH_STEP_X, step_x);
		reg_write(dsf_pkg::REG_DEPTH_STEP_Y, step_y);
		reg_write(dsf_pkg::REG_BUFFER_WIDTH, pitch);
		reg_write(dsf_pkg::REG_BUFFER_BASE, base);
	endtask

	// Holds until every request is in and every depth write has come out, then lets the
	// pipeline clear. The check runs on the falling edge
	// so that it sees the driver's state after the rising edge has settled.
	task automatic wait_idle();
		while (pending_spans.size() != 0 || start || depth_writes_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic push_span(int x, int y, int len);
		pending_spans.push_back('{dsf_pkg::COORD_W'(x), dsf_pkg::COORD_W'(y),
			dsf_pkg::LEN_IN_W'(len)});
	endtask

	// Mostly full-range pieces, a good share of short ones, and a few zero-length and
	// over-long requests.
	task automatic push_random_spans(int count);
		int pick;
		int len;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 5)
				len = 0;
			else if (pick < 12)
				len = $urandom_range(127, PIXELS_PER_SPAN + 1);
			else if (pick < 40)
				len = $urandom_range(8, 1);
			else
				len = $urandom_range(PIXELS_PER_SPAN, 1);
			push_span($urandom_range(1023), $urandom_range(1023), len);
		end
	endtask

	task automatic run_phase(int idle_pct, int count);
		sender_idle_pct = idle_pct;
		push_random_spans(count);
		wait_idle();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Reset values of the registers: flat plane, 320-element rows.
		sender_idle_pct = 21;
		push_span(0, 0, 1);
		push_span(1023, 1023, 64);
		push_span(5, 7, 3);
		wait_idle();

		// Directed requests on a sloped plane: field extremes, alternating bit patterns,
		// zero length and lengths past the piece limit.
		program_plane(32'h4000_0000, 32'h0001_2345, 32'hFFF0_0000, 32'd1024, 32'h12_3456);
		push_span(0, 0, 1);
		push_span(1023, 1023, 64);
		push_span(1023, 0, 127);
		push_span(0, 1023, 0);
		push_span(512, 511, 65);
		push_span(341, 682, 85);
		push_span(682, 341, 42);
		push_span(0, 0, 64);
		push_span(1000, 3, 63);
		push_span(17, 900, 2);
		push_span(1023, 1023, 0);
		push_span(100, 200, 1);
		wait_idle();
		run_phase(21, 67);

		// Largest magnitudes, a row pitch past the screen limit and a base at the top of
		// the address space so that addresses wrap.
		program_plane(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd2047, 32'hFF_FFFF);
		run_phase(21, 67);

		// Zero row pitch folds all rows onto one; a write past the register list changes
		// nothing.
		program_plane(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'hFF_FF00);
		reg_write(REG_UNUSED, $urandom);
		run_phase(48, 67);

		program_plane($urandom, $urandom, $urandom, 32'd1, $urandom);
		run_phase(48, 67);

		program_plane($urandom, $urandom, $urandom, $urandom_range(1024, 1), $urandom);
		run_phase(0, 67);

		program_plane($urandom, $urandom, $urandom, 32'd1025, $urandom);
		run_phase(0, 67);

		if (failures == 0 && depth_writes_due.size() == 0) begin
			$display("depth_span_fill_top test passed");
		end else begin
			$display("depth_span_fill_top test failed");
		end
		$finish;
	end

endmodule
